>>> rtl/ctnt_pkg.sv
// package for the class constrained nearest tour block
// sizes, request codes, word types and controller states; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ctnt_pkg;

    // store sizing
    localparam int MAX_POINTS = 2048;
    localparam int ADDR_W     = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);

    // field widths
    localparam int COORD_W = 16;
    localparam int CLASS_W = 3;
    localparam int INDEX_W = 12;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;

    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [CNT_W-1:0]   cnt_t;
    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [CLASS_W-1:0] class_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [SQ_W-1:0]    sq_t;
    typedef logic [DIST_W-1:0]  dist_t;
    typedef logic [1:0]         req_t;

    // request codes
    localparam req_t REQ_LOAD    = 2'd0;
    localparam req_t REQ_STEP    = 2'd1;
    localparam req_t REQ_RESTART = 2'd2;

    // input word
    typedef struct packed {
        req_t   req_type;
        coord_t coord_x;
        coord_t coord_y;
        class_t point_class;
    } in_word_t;

    // result word
    typedef struct packed {
        logic   found;
        index_t chosen_index;
        coord_t chosen_x;
        coord_t chosen_y;
        dist_t  squared_distance;
    } out_word_t;

    // one stored point
    typedef struct packed {
        coord_t x;
        coord_t y;
        class_t cls;
    } point_t;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

>>> rtl/ctnt_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module ctnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

>>> rtl/class_constrained_nearest_tour.sv
// top level of the class constrained greedy nearest tour builder
// uses ctnt_pkg and two ctnt_ram instances (point store, visited marks)
//
// usage:
//   in channel (in_valid, in_stall, in_data) takes request words: load a point,
//   route step for a class, or restart the route. out channel (out_valid,
//   out_stall, out_data) returns one word per route step and nothing else.
//   a load never stalls the input and is dropped once the store holds MAX_POINTS.
//   a route step reads every stored point once through the single read port
//   of the point memory, then the distance pipeline (r1, s2, s3) drains and
//   the result register loads; with an empty store the step goes straight to
//   the result. a restart sweeps the visited memory one entry per cycle with
//   the input stalled until every loaded entry is cleared.
//   the result register parts the sides: a stalled result keeps its word and
//   loads or restarts are still taken; the next step waits only at its end.
//   reset empties the store, puts the position at the origin and clears
//   the output valid; the memories need no clearing pass since only entries
//   below the point count are ever read and a load clears its visited mark.
`timescale 1ns / 1ps
`default_nettype none

module class_constrained_nearest_tour (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire ctnt_pkg::in_word_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output ctnt_pkg::out_word_t      out_data
);

    ctnt_pkg::state_t    state_reg, state_next;
    ctnt_pkg::cnt_t      count_reg;
    ctnt_pkg::coord_t    cur_x_reg, cur_y_reg;
    ctnt_pkg::addr_t     scan_idx_reg, clr_idx_reg;
    ctnt_pkg::class_t    cls_reg;

    // pipeline
    logic                r1_valid_reg, s2_valid_reg, s3_valid_reg;
    ctnt_pkg::addr_t     r1_idx_reg, s2_idx_reg, s3_idx_reg;
    ctnt_pkg::coord_t    s2_x_reg, s2_y_reg, s3_x_reg, s3_y_reg;
    ctnt_pkg::coord_t    s2_dx_reg, s2_dy_reg;
    ctnt_pkg::sq_t       s3_sqx_reg, s3_sqy_reg;

    // best candidate so far
    logic                have_reg;
    ctnt_pkg::addr_t     best_idx_reg;
    ctnt_pkg::coord_t    best_x_reg, best_y_reg;
    ctnt_pkg::dist_t     best_d_reg;

    logic                out_valid_reg;
    ctnt_pkg::out_word_t out_data_reg;

    // memory ports
    logic                pt_we;
    ctnt_pkg::point_t    pt_wdata, pt_rdata;
    logic                vis_we;
    ctnt_pkg::addr_t     vis_waddr;
    logic [0:0]          vis_wdata, vis_rdata;

    logic                accept, full, last_scan, last_clr, pipe_empty;
    logic                issue, commit, commit_hit;
    logic                cand;
    ctnt_pkg::coord_t    dx, dy;
    ctnt_pkg::dist_t     cand_d;

    ctnt_pkg::cnt_t      count_m1;

    assign count_m1   = count_reg - ctnt_pkg::cnt_t'(1);
    assign accept     = in_valid && !in_stall;
    assign full       = count_reg == ctnt_pkg::cnt_t'(ctnt_pkg::MAX_POINTS);
    assign last_scan  = scan_idx_reg == count_m1[ctnt_pkg::ADDR_W-1:0];
    assign last_clr   = clr_idx_reg == count_m1[ctnt_pkg::ADDR_W-1:0];
    assign pipe_empty = !r1_valid_reg && !s2_valid_reg && !s3_valid_reg;

    // point store and visited marks
    assign pt_wdata = '{x: in_data.coord_x, y: in_data.coord_y, cls: in_data.point_class};

    ctnt_ram #(
        .WIDTH ($bits(ctnt_pkg::point_t)),
        .DEPTH (ctnt_pkg::MAX_POINTS)
    ) u_point_ram (
        .clk     (clk),
        .wr_en   (pt_we),
        .wr_addr (count_reg[ctnt_pkg::ADDR_W-1:0]),
        .wr_data (pt_wdata),
        .rd_addr (scan_idx_reg),
        .rd_data (pt_rdata)
    );

    ctnt_ram #(
        .WIDTH (1),
        .DEPTH (ctnt_pkg::MAX_POINTS)
    ) u_visited_ram (
        .clk     (clk),
        .wr_en   (vis_we),
        .wr_addr (vis_waddr),
        .wr_data (vis_wdata),
        .rd_addr (scan_idx_reg),
        .rd_data (vis_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ctnt_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.req_type)
                        ctnt_pkg::REQ_STEP:
                            state_next = (count_reg == '0) ? ctnt_pkg::S_DONE
                                                            : ctnt_pkg::S_SCAN;
                        ctnt_pkg::REQ_RESTART:
                            state_next = (count_reg == '0) ? ctnt_pkg::S_IDLE
                                                            : ctnt_pkg::S_CLEAR;
                        default:
                            state_next = ctnt_pkg::S_IDLE;
                    endcase
                end
            end
            ctnt_pkg::S_CLEAR:
            begin
                if (last_clr)
                begin
                    state_next = ctnt_pkg::S_IDLE;
                end
            end
            ctnt_pkg::S_SCAN:
            begin
                if (last_scan)
                begin
                    state_next = ctnt_pkg::S_DRAIN;
                end
            end
            ctnt_pkg::S_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ctnt_pkg::S_DONE;
                end
            end
            ctnt_pkg::S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ctnt_pkg::S_IDLE;
                end
            end
            default:
                state_next = ctnt_pkg::S_IDLE;
        endcase
    end

    // controller outputs
    always_comb
    begin
        in_stall   = state_reg != ctnt_pkg::S_IDLE;
        issue      = state_reg == ctnt_pkg::S_SCAN;
        commit     = (state_reg == ctnt_pkg::S_DONE) && (!out_valid_reg || !out_stall);
        commit_hit = commit && have_reg;
        pt_we      = 1'b0;
        vis_we     = 1'b0;
        vis_waddr  = count_reg[ctnt_pkg::ADDR_W-1:0];
        vis_wdata  = 1'b0;
        case (state_reg)
            ctnt_pkg::S_IDLE:
            begin
                if (accept && in_data.req_type == ctnt_pkg::REQ_LOAD && !full)
                begin
                    pt_we  = 1'b1;
                    vis_we = 1'b1;
                end
            end
            ctnt_pkg::S_CLEAR:
            begin
                vis_we    = 1'b1;
                vis_waddr = clr_idx_reg;
            end
            ctnt_pkg::S_DONE:
            begin
                vis_we    = commit_hit;
                vis_waddr = best_idx_reg;
                vis_wdata = 1'b1;
            end
            default:
            begin
                vis_we = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ctnt_pkg::S_IDLE;
            count_reg     <= '0;
            cur_x_reg     <= '0;
            cur_y_reg     <= '0;
            scan_idx_reg  <= '0;
            clr_idx_reg   <= '0;
            r1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            have_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            r1_valid_reg <= issue;
            s2_valid_reg <= cand;
            s3_valid_reg <= s2_valid_reg;
            if (pt_we)
            begin
                count_reg <= count_reg + ctnt_pkg::cnt_t'(1);
            end
            if (accept && in_data.req_type == ctnt_pkg::REQ_STEP)
            begin
                scan_idx_reg <= '0;
            end
            else if (issue)
            begin
                scan_idx_reg <= scan_idx_reg + ctnt_pkg::addr_t'(1);
            end
            if (accept && in_data.req_type == ctnt_pkg::REQ_RESTART)
            begin
                clr_idx_reg <= '0;
                cur_x_reg   <= '0;
                cur_y_reg   <= '0;
            end
            else if (state_reg == ctnt_pkg::S_CLEAR)
            begin
                clr_idx_reg <= clr_idx_reg + ctnt_pkg::addr_t'(1);
            end
            else if (commit_hit)
            begin
                cur_x_reg <= best_x_reg;
                cur_y_reg <= best_y_reg;
            end
            if (accept && in_data.req_type == ctnt_pkg::REQ_STEP)
            begin
                have_reg <= 1'b0;
            end
            else if (s3_valid_reg && (!have_reg || cand_d < best_d_reg))
            begin
                have_reg <= 1'b1;
            end
            if (commit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // candidate test and absolute differences on the read word
    always_comb
    begin
        cand   = r1_valid_reg && !vis_rdata[0] && (pt_rdata.cls == cls_reg);
        dx     = (cur_x_reg > pt_rdata.x) ? cur_x_reg - pt_rdata.x : pt_rdata.x - cur_x_reg;
        dy     = (cur_y_reg > pt_rdata.y) ? cur_y_reg - pt_rdata.y : pt_rdata.y - cur_y_reg;
        cand_d = {1'b0, s3_sqx_reg} + {1'b0, s3_sqy_reg};
    end

    // payload registers of the pipeline, best candidate and result
    always_ff @(posedge clk)
    begin
        if (accept && in_data.req_type == ctnt_pkg::REQ_STEP)
        begin
            cls_reg <= in_data.point_class;
        end
        r1_idx_reg <= scan_idx_reg;
        s2_idx_reg <= r1_idx_reg;
        s2_x_reg   <= pt_rdata.x;
        s2_y_reg   <= pt_rdata.y;
        s2_dx_reg  <= dx;
        s2_dy_reg  <= dy;
        s3_idx_reg <= s2_idx_reg;
        s3_x_reg   <= s2_x_reg;
        s3_y_reg   <= s2_y_reg;
        s3_sqx_reg <= ctnt_pkg::sq_t'(s2_dx_reg) * ctnt_pkg::sq_t'(s2_dx_reg);
        s3_sqy_reg <= ctnt_pkg::sq_t'(s2_dy_reg) * ctnt_pkg::sq_t'(s2_dy_reg);
        // strict compare keeps the lowest index on a tie
        if (s3_valid_reg && (!have_reg || cand_d < best_d_reg))
        begin
            best_idx_reg <= s3_idx_reg;
            best_x_reg   <= s3_x_reg;
            best_y_reg   <= s3_y_reg;
            best_d_reg   <= cand_d;
        end
        if (commit)
        begin
            if (have_reg)
            begin
                out_data_reg.found            <= 1'b1;
                out_data_reg.chosen_index     <= ctnt_pkg::index_t'(
                    ctnt_pkg::cnt_t'(best_idx_reg) + ctnt_pkg::cnt_t'(1));
                out_data_reg.chosen_x         <= best_x_reg;
                out_data_reg.chosen_y         <= best_y_reg;
                out_data_reg.squared_distance <= best_d_reg;
            end
            else
            begin
                out_data_reg <= '0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ctnt_pkg::cnt_t'(ctnt_pkg::MAX_POINTS))
        else $error("point count beyond store size");

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ctnt_pkg::S_SCAN |-> ctnt_pkg::cnt_t'(scan_idx_reg) < count_reg)
        else $error("scan reads beyond loaded points");

    a_found_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.found |->
            out_data_reg.chosen_index != '0 &&
            out_data_reg.chosen_index <= ctnt_pkg::index_t'(count_reg))
        else $error("chosen index outside loaded points");

    a_move_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
        commit_hit |=> cur_x_reg == $past(best_x_reg) && cur_y_reg == $past(best_y_reg))
        else $error("position not moved to chosen point");

    a_done_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ctnt_pkg::S_DONE |-> pipe_empty)
        else $error("result taken before distance pipeline drained");

endmodule

`default_nettype wire
